// ===== sv/tsc_pkg.sv =====
// shared types, constants and arithmetic helpers for the series sine/cosine pipeline
package tsc_pkg;

    localparam int ANGLE_W = 19;
    localparam int OUT_W   = 18;
    localparam int ORD_W   = 5;
    localparam int X2_W    = 38;
    localparam int TERM_W  = 39;
    localparam int SUM_W   = 40;
    localparam int PLO_W   = 58;
    localparam int PHI_W   = 57;
    localparam int RECIP_W = 32;
    localparam int NUM_W   = 6;

    localparam int DEFAULT_MAX_TERMS_ORDER = 20;
    localparam logic [ORD_W-1:0] MAX_ORDER_RESET = 5'd20;

    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] Q32_ONE = 40'sh01_0000_0000;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [ORD_W-1:0]        order;
        logic [X2_W-1:0]         x2;
        logic [TERM_W-1:0]       sterm;
        logic [TERM_W-1:0]       cterm;
        logic signed [SUM_W-1:0] ssum;
        logic signed [SUM_W-1:0] csum;
        logic [TERM_W-1:0]       wterm;
        logic [PLO_W-1:0]        p_lo;
        logic [PHI_W-1:0]        p_hi;
    } pipe_t;

    // rounded Q0.32 reciprocal of n*(n-1)
    function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            6'd2:    r = 32'd2147483648;
            6'd3:    r = 32'd715827883;
            6'd4:    r = 32'd357913941;
            6'd5:    r = 32'd214748365;
            6'd6:    r = 32'd143165577;
            6'd7:    r = 32'd102261126;
            6'd8:    r = 32'd76695845;
            6'd9:    r = 32'd59652324;
            6'd10:   r = 32'd47721859;
            6'd11:   r = 32'd39045157;
            6'd12:   r = 32'd32537631;
            6'd13:   r = 32'd27531842;
            6'd14:   r = 32'd23598721;
            6'd15:   r = 32'd20452225;
            6'd16:   r = 32'd17895697;
            6'd17:   r = 32'd15790321;
            6'd18:   r = 32'd14035841;
            6'd19:   r = 32'd12558384;
            6'd20:   r = 32'd11302546;
            6'd21:   r = 32'd10226113;
            6'd22:   r = 32'd9296466;
            6'd23:   r = 32'd8488078;
            6'd24:   r = 32'd7780738;
            6'd25:   r = 32'd7158279;
            6'd26:   r = 32'd6607642;
            6'd27:   r = 32'd6118187;
            6'd28:   r = 32'd5681174;
            6'd29:   r = 32'd5289369;
            6'd30:   r = 32'd4936744;
            6'd31:   r = 32'd4618244;
            6'd32:   r = 32'd4329604;
            default: r = '0;
        endcase
        return r;
    endfunction

    // combine split partial products, drop 32 fraction bits, clamp magnitude
    function automatic logic [TERM_W-1:0] join_sat(input logic [PHI_W-1:0] p_hi,
                                                   input logic [PLO_W-1:0] p_lo);
        logic [PHI_W+19:0] full;
        logic [PHI_W-13:0] shr;
        full = {p_hi, 20'd0} + {19'd0, p_lo};
        shr  = full[PHI_W+19:32];
        return (|shr[PHI_W-13:TERM_W]) ? TERM_MAX : shr[TERM_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                        input logic [TERM_W-1:0] t,
                                                        input logic sub);
        logic signed [SUM_W:0] se;
        logic signed [SUM_W:0] te;
        logic signed [SUM_W:0] r;
        se = {s[SUM_W-1], s};
        te = {2'b00, t};
        r  = sub ? (se - te) : (se + te);
        if (r[SUM_W] != r[SUM_W-1])
            return r[SUM_W] ? SUM_MIN : SUM_MAX;
        return r[SUM_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-17:0] q;
        q = s[SUM_W-1:16];
        if (q[SUM_W-17:OUT_W-1] != {(SUM_W-16-OUT_W+1){q[SUM_W-17]}})
            return q[SUM_W-17] ? OUT_MIN : OUT_MAX;
        return q[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/taylor_sine_cosine_top.sv =====
// series sine/cosine evaluator: one angle in, one sine/cosine pair out
//
// usage notes
// - input channel: in_valid/in_ready with angle (unsigned Q3.16 radians)
// - output channel: out_valid/out_ready with sine and cosine (signed Q2.16)
// - config channel: cfg_valid/cfg_ready with max_order, always ready; write it
//   only while the pipeline is empty
// - one transfer per cycle is sustained while out_ready stays high; one angle enters every clock
// - between the input transfer and out_valid lie a squaring stage loaded at the
//   input transfer, four stages per series power (two split multiplies, each
//   partial products then sum and clamp), and an output saturation stage
// - the whole pipeline advances together; when the receiver holds out_ready
//   low with a result waiting, every stage holds and in_ready drops, nothing
//   is lost or repeated
// - reset empties the pipeline and sets max_order to 20
// - powers 2 to MAX_TERMS_ORDER are computed; those above max_order are not summed
module taylor_sine_cosine_top #(
    parameter int MAX_TERMS_ORDER = tsc_pkg::DEFAULT_MAX_TERMS_ORDER
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tsc_pkg::ANGLE_W-1:0]          angle,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tsc_pkg::OUT_W-1:0]     sine,
    output logic signed [tsc_pkg::OUT_W-1:0]     cosine,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tsc_pkg::ORD_W-1:0]            max_order
);

    localparam int NS = 4 * (MAX_TERMS_ORDER - 1);

    logic [tsc_pkg::ORD_W-1:0]     max_order_reg;
    logic [NS+1:0]                 valid_reg;
    tsc_pkg::pipe_t                stg_reg  [0:NS];
    tsc_pkg::pipe_t                stg_next [0:NS];
    logic signed [tsc_pkg::OUT_W-1:0] sine_reg;
    logic signed [tsc_pkg::OUT_W-1:0] cosine_reg;
    logic                          adv;

    assign adv       = !valid_reg[NS+1] || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = valid_reg[NS+1];
    assign sine      = sine_reg;
    assign cosine    = cosine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_order_reg <= tsc_pkg::MAX_ORDER_RESET;
        else if (cfg_valid && cfg_ready)
            max_order_reg <= max_order;
    end

    // entry stage: x = angle << 16 and x^2 in Q6.32 is exactly angle^2
    always_comb
    begin
        stg_next[0]       = '0;
        stg_next[0].order = max_order_reg;
        stg_next[0].x2    = {19'd0, angle} * {19'd0, angle};
        stg_next[0].sterm = {4'd0, angle, 16'd0};
        stg_next[0].cterm = tsc_pkg::TERM_W'(tsc_pkg::Q32_ONE);
        stg_next[0].ssum  = {5'd0, angle, 16'd0};
        stg_next[0].csum  = tsc_pkg::Q32_ONE;
    end

    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        localparam int N  = 2 + (s - 1) / 4;
        localparam int PH = (s - 1) % 4;
        localparam logic [tsc_pkg::NUM_W-1:0] NV = tsc_pkg::NUM_W'(N);
        localparam logic [tsc_pkg::RECIP_W-1:0] RC = tsc_pkg::recip(NV);

        if (PH == 0)
        begin : g_mul_x2
            always_comb
            begin
                logic [tsc_pkg::TERM_W-1:0] t;
                stg_next[s] = stg_reg[s-1];
                t = NV[0] ? stg_reg[s-1].sterm : stg_reg[s-1].cterm;
                stg_next[s].p_lo = {38'd0, t[19:0]} * {20'd0, stg_reg[s-1].x2};
                stg_next[s].p_hi = {38'd0, t[38:20]} * {19'd0, stg_reg[s-1].x2};
            end
        end
        else if (PH == 1)
        begin : g_join_x2
            always_comb
            begin
                stg_next[s] = stg_reg[s-1];
                stg_next[s].wterm = tsc_pkg::join_sat(stg_reg[s-1].p_hi, stg_reg[s-1].p_lo);
            end
        end
        else if (PH == 2)
        begin : g_mul_recip
            always_comb
            begin
                stg_next[s] = stg_reg[s-1];
                stg_next[s].p_lo = {38'd0, stg_reg[s-1].wterm[19:0]} * {26'd0, RC};
                stg_next[s].p_hi = {38'd0, stg_reg[s-1].wterm[38:20]} * {25'd0, RC};
            end
        end
        else
        begin : g_accum
            always_comb
            begin
                logic [tsc_pkg::TERM_W-1:0] t;
                logic                       use_term;
                stg_next[s] = stg_reg[s-1];
                t = tsc_pkg::join_sat(stg_reg[s-1].p_hi, stg_reg[s-1].p_lo);
                use_term = ({1'b0, stg_reg[s-1].order} >= NV);
                if (NV[0])
                begin
                    stg_next[s].sterm = t;
                    if (use_term)
                        stg_next[s].ssum = tsc_pkg::sat_add(stg_reg[s-1].ssum, t, NV[1]);
                end
                else
                begin
                    stg_next[s].cterm = t;
                    if (use_term)
                        stg_next[s].csum = tsc_pkg::sat_add(stg_reg[s-1].csum, t, NV[1]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NS:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= NS; i++)
                stg_reg[i] <= stg_next[i];
            sine_reg   <= tsc_pkg::to_out(stg_reg[NS].ssum);
            cosine_reg <= tsc_pkg::to_out(stg_reg[NS].csum);
        end
    end

    // an empty output stage never blocks the input side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // a held pipeline keeps every valid bit in place
    a_hold_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("valid bits moved during stall");

    // nothing in flight and no transfer in means no result next cycle
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NS:0] == '0) && !(in_valid && in_ready) && !out_valid |=> !out_valid)
        else $error("result appeared without an input transfer");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the series sine/cosine evaluator
module tb_top;

    localparam int ORDER_CAP  = tsc_pkg::DEFAULT_MAX_TERMS_ORDER;
    localparam int LATENCY    = 4 * (ORDER_CAP - 1) + 2;
    localparam int ANGLE_TOP  = 411775;

    typedef struct packed {
        logic signed [tsc_pkg::OUT_W-1:0] sine;
        logic signed [tsc_pkg::OUT_W-1:0] cosine;
    } trig_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [tsc_pkg::ANGLE_W-1:0]      angle;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [tsc_pkg::OUT_W-1:0] sine;
    logic signed [tsc_pkg::OUT_W-1:0] cosine;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tsc_pkg::ORD_W-1:0]        max_order;

    logic [tsc_pkg::ANGLE_W-1:0] pending_angles[$];
    trig_t                       expected_trig[$];
    logic [tsc_pkg::ORD_W-1:0]   order_setting;
    int                          errors;
    int                          burst_left;
    int                          gap_left;
    int                          stall_phase;
    bit                          hold_sender;

    taylor_sine_cosine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sine      (sine),
        .cosine    (cosine),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .max_order (max_order)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // floor(a*b / 2^32)
    function automatic logic [79:0] mul_frac(input logic [39:0] a, input logic [39:0] b);
        logic [79:0] p;
        p = {40'd0, a} * {40'd0, b};
        return p >> 32;
    endfunction

    function automatic logic [tsc_pkg::TERM_W-1:0] clamp_mag(input logic [79:0] v);
        return (v > {41'd0, tsc_pkg::TERM_MAX}) ? tsc_pkg::TERM_MAX
                                                : v[tsc_pkg::TERM_W-1:0];
    endfunction

    function automatic logic signed [41:0] clamp_sum(input logic signed [41:0] v);
        if (v > 42'sd549755813887)
            return 42'sd549755813887;
        if (v < -42'sd549755813888)
            return -42'sd549755813888;
        return v;
    endfunction

    function automatic logic signed [tsc_pkg::OUT_W-1:0] scale_out(
        input logic signed [41:0] s);
        logic signed [41:0] q;
        q = s >>> 16;
        if (q > 42'sd131071)
            return tsc_pkg::OUT_MAX;
        if (q < -42'sd131072)
            return tsc_pkg::OUT_MIN;
        return q[tsc_pkg::OUT_W-1:0];
    endfunction

    function automatic trig_t series_sine_cosine(input logic [tsc_pkg::ANGLE_W-1:0] a,
                                                 input logic [tsc_pkg::ORD_W-1:0] ord);
        logic [39:0]        x;
        logic [39:0]        x2;
        logic [79:0]        p;
        logic [39:0]        st;
        logic [39:0]        ct;
        logic [39:0]        rc;
        logic signed [41:0] ssum;
        logic signed [41:0] csum;
        int                 lim;
        int                 d;
        trig_t              r;
        x    = {5'd0, a, 16'd0};
        p    = mul_frac(x, x);
        x2   = p[39:0];
        st   = x;
        ct   = 40'h01_0000_0000;
        ssum = $signed({2'b00, x});
        csum = 42'sh01_0000_0000;
        lim  = (ord > ORDER_CAP) ? ORDER_CAP : ord;
        for (int n = 2; n <= lim; n++)
        begin
            d  = n * (n - 1);
            rc = 40'((64'h1_0000_0000 + 64'(d / 2)) / 64'(d));
            if (n % 2 == 0)
            begin
                ct   = {1'b0, clamp_mag(mul_frac({1'b0, clamp_mag(mul_frac(ct, x2))}, rc))};
                csum = clamp_sum(((n >> 1) & 1) ? csum - $signed({2'b00, ct})
                                                : csum + $signed({2'b00, ct}));
            end
            else
            begin
                st   = {1'b0, clamp_mag(mul_frac({1'b0, clamp_mag(mul_frac(st, x2))}, rc))};
                ssum = clamp_sum(((n >> 1) & 1) ? ssum - $signed({2'b00, st})
                                                : ssum + $signed({2'b00, st}));
            end
        end
        r.sine   = scale_out(ssum);
        r.cosine = scale_out(csum);
        return r;
    endfunction

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            angle      <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready)
                expected_trig.push_back(series_sine_cosine(angle, order_setting));
            if (gap_left > 0 || hold_sender || pending_angles.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                angle    <= pending_angles.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 512 < 128)
                out_ready <= 1'b1;
            else
                out_ready <= ((stall_phase % 7) != 3) && ($urandom_range(4, 0) != 0);
            if (out_valid && out_ready)
            begin
                if (expected_trig.size() == 0)
                begin
                    $display("%0t: unexpected transfer sine %0d cosine %0d",
                             $time, sine, cosine);
                    errors++;
                end
                else
                begin
                    trig_t e;
                    e = expected_trig.pop_front();
                    if (sine !== e.sine)
                    begin
                        $display("%0t: sine expected %0d actual %0d", $time, e.sine, sine);
                        errors++;
                    end
                    if (cosine !== e.cosine)
                    begin
                        $display("%0t: cosine expected %0d actual %0d",
                                 $time, e.cosine, cosine);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic drain();
        while (pending_angles.size() != 0 || in_valid || expected_trig.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_order(input logic [tsc_pkg::ORD_W-1:0] v);
        cfg_valid <= 1'b1;
        max_order <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        order_setting <= v;
        @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(9, 0);
            if (k == 0)
                pending_angles.push_back(tsc_pkg::ANGLE_W'($urandom));
            else if (k == 1)
                pending_angles.push_back(tsc_pkg::ANGLE_W'($urandom_range(2000, 0)));
            else
                pending_angles.push_back(tsc_pkg::ANGLE_W'($urandom_range(ANGLE_TOP, 0)));
        end
    endtask

    initial
    begin
        logic [tsc_pkg::ORD_W-1:0] orders[6];
        orders        = '{5'd2, 5'd20, 5'd0, 5'd31, 5'd7, 5'd13};
        errors        = 0;
        hold_sender   = 1'b0;
        order_setting = tsc_pkg::MAX_ORDER_RESET;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        max_order     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, quadrant points, above 2*pi
        pending_angles.push_back(19'd0);
        pending_angles.push_back(19'd1);
        pending_angles.push_back(19'd102944);
        pending_angles.push_back(19'd205887);
        pending_angles.push_back(19'd308831);
        pending_angles.push_back(19'(ANGLE_TOP));
        pending_angles.push_back(19'h7FFFF);
        pending_angles.push_back(19'h55555);
        pending_angles.push_back(19'h2AAAA);
        pending_angles.push_back(19'd65536);
        queue_random(200);
        // sender waits for every result mid-phase
        while (pending_angles.size() >= 100)
            @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_trig.size() != 0)
            @(posedge clk);
        hold_sender = 1'b0;
        drain();

        foreach (orders[i])
        begin
            write_order(orders[i]);
            pending_angles.push_back(19'd0);
            pending_angles.push_back(19'h7FFFF);
            pending_angles.push_back(19'(ANGLE_TOP));
            queue_random(140);
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
